// ===== design/gbcd_pkg.sv =====
// ----------------------------------------------------------------------------
// gbcd_pkg
// Shared types and constants for the greedy bounded change dispenser.
// ----------------------------------------------------------------------------
`default_nettype none

package gbcd_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int VAL_W   = 16;

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_ADD      = 2'd1,
    OP_DISPENSE = 2'd2,
    OP_UNUSED   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_LINE    = 3'd0,
    ST_NOTHING = 3'd1,
    ST_FAIL    = 3'd2,
    ST_ACCEPT  = 3'd3,
    ST_REJECT  = 3'd4
  } status_t;

  // Sequencer states of the top level.
  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SORT_RD, S_SORT_CMP, S_SORT_PUT, S_DIV_RD, S_DIV_GO,
    S_DIV_WAIT, S_CHECK, S_EMIT_RD, S_EMIT, S_ONE
  } state_t;

  // Divider handshake between sequencer and shared divide unit.
  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] dividend;
    logic [VAL_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== design/gbcd_div.sv =====
// ----------------------------------------------------------------------------
// gbcd_div
// Restoring divider, one quotient bit per cycle; the quotient is ready when
// done is raised after start.
// ----------------------------------------------------------------------------
`default_nettype none

module gbcd_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  gbcd_pkg::div_req_t     req,
  output gbcd_pkg::div_rsp_t     rsp
);

  localparam int W = gbcd_pkg::VAL_W;

  logic           busy;
  logic [4:0]     step;
  logic [W-1:0]   quo;
  logic [W:0]     rem;
  logic [W-1:0]   dvs;
  logic [W:0]     trial;
  logic           done;

  assign trial = {rem[W-1:0], quo[W-1]} - {1'b0, dvs};

  // Shift in one dividend bit per cycle and try the subtract.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 5'd1;
        if (step == 5'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      if (!trial[W]) begin
        rem <= trial;
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= {rem[W-1:0], quo[W-1]};
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

`ifndef NO_ASSERTIONS
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> $past(busy)) else $error("divider done without work");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy && !rsp.done |=> busy || rsp.done) else $error("divider dropped busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    rsp.done |=> !rsp.done) else $error("divider done held");
`endif

endmodule

`default_nettype wire

// ===== design/greedy_bounded_change_dispenser.sv =====
// Clear/add/reject go through S_DECODE and then S_ONE to the result register.
// A dispense request takes an insertion sort (up to ENTRIES*(ENTRIES-1)/2
// compares, plus a read per entry) and one serial division step per entry on
// the shared divider before the first line; each dispense line then waits on
// the output.
// Throughput: one item at a time; tready is low while an item is in work.
// Reset: synchronous; clears the entry count and control; table contents stay.
// ----------------------------------------------------------------------------
// greedy_bounded_change_dispenser
// Wallet table with a greedy change maker driven by a shared serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_bounded_change_dispenser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [55:0] s_tdata,   // opcode[1:0], denomination[17:2], available[33:18], amount[49:34]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // status[2:0], out_denomination[18:3], quantity[34:19]
  output logic             m_tlast
);

  localparam int N  = gbcd_pkg::ENTRIES;
  localparam int IW = gbcd_pkg::IDX_W;
  localparam int CW = gbcd_pkg::CNT_W;
  localparam int W  = gbcd_pkg::VAL_W;

  // Table memories and sorted order.
  logic [W-1:0]  wal_val [N];
  logic [W-1:0]  wal_cnt [N];
  logic [W-1:0]  taken   [N];
  logic [IW-1:0] order   [N];

  gbcd_pkg::state_t state, state_next;
  logic [CW-1:0]   used;
  logic [CW-1:0]   i, j;
  logic [W-1:0]    rem;
  logic [W-1:0]    amt;
  logic [1:0]      op;
  logic [W-1:0]    in_den, in_cnt;
  logic [W-1:0]    v_val, v_cnt, o_val, o_cnt;
  logic [W-1:0]    d_val, d_cnt;
  logic [CW-1:0]   last_idx;
  logic            any_taken;
  logic [2:0]      out_st;
  logic [W-1:0]    out_den, out_q;
  logic            out_last;
  logic [31:0]     prod;
  logic [W-1:0]    take;
  logic            sort_shift;

  gbcd_pkg::div_req_t dreq;
  gbcd_pkg::div_rsp_t drsp;

  gbcd_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign s_tready = (state == gbcd_pkg::S_IDLE) && !m_tvalid;
  assign m_tdata  = {5'd0, out_q, out_den, out_st};
  assign m_tlast  = out_last;

  assign dreq.start    = (state == gbcd_pkg::S_DIV_GO);
  assign dreq.dividend = rem;
  assign dreq.divisor  = d_val;

  assign take = (drsp.quotient > d_cnt) ? d_cnt : drsp.quotient;
  assign prod = take * d_val;

  // New entry ranks ahead of the one in the slot above it.
  assign sort_shift = (j != '0) &&
                      (v_val > o_val || (v_val == o_val && v_cnt > o_cnt));

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      gbcd_pkg::S_IDLE:     if (s_tvalid && s_tready) state_next = gbcd_pkg::S_DECODE;
      gbcd_pkg::S_DECODE:   begin
        if (op == gbcd_pkg::OP_DISPENSE) state_next = gbcd_pkg::S_SORT_RD;
        else state_next = gbcd_pkg::S_ONE;
      end
      gbcd_pkg::S_SORT_RD:
        state_next = (i >= used) ? gbcd_pkg::S_DIV_RD : gbcd_pkg::S_SORT_CMP;
      gbcd_pkg::S_SORT_CMP: state_next = gbcd_pkg::S_SORT_PUT;
      gbcd_pkg::S_SORT_PUT:
        state_next = sort_shift ? gbcd_pkg::S_SORT_CMP : gbcd_pkg::S_SORT_RD;
      gbcd_pkg::S_DIV_RD:
        state_next = (i >= used) ? gbcd_pkg::S_CHECK : gbcd_pkg::S_DIV_GO;
      gbcd_pkg::S_DIV_GO:   state_next = gbcd_pkg::S_DIV_WAIT;
      gbcd_pkg::S_DIV_WAIT: if (drsp.done) state_next = gbcd_pkg::S_DIV_RD;
      gbcd_pkg::S_CHECK:    begin
        if (amt == '0 || rem != '0 || !any_taken) state_next = gbcd_pkg::S_ONE;
        else state_next = gbcd_pkg::S_EMIT_RD;
      end
      gbcd_pkg::S_EMIT_RD:  if (!m_tvalid) state_next = gbcd_pkg::S_EMIT;
      gbcd_pkg::S_EMIT:     begin
        if (!m_tvalid)
          state_next = (i == last_idx) ? gbcd_pkg::S_IDLE : gbcd_pkg::S_EMIT_RD;
      end
      gbcd_pkg::S_ONE:      if (!m_tvalid) state_next = gbcd_pkg::S_IDLE;
      default:              state_next = gbcd_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= gbcd_pkg::S_IDLE;
    else state <= state_next;
  end

  // Control, datapath and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      used     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        gbcd_pkg::S_IDLE: if (s_tvalid && s_tready) begin
          op     <= s_tdata[1:0];
          in_den <= s_tdata[17:2];
          in_cnt <= s_tdata[33:18];
          amt    <= s_tdata[49:34];
          i      <= '0;
        end
        gbcd_pkg::S_DECODE: begin
          rem       <= amt;
          any_taken <= 1'b0;
          out_den   <= '0;
          out_q     <= '0;
          out_last  <= 1'b1;
          case (op)
            gbcd_pkg::OP_CLEAR: begin
              used <= '0;
              out_st <= gbcd_pkg::ST_ACCEPT;
            end
            gbcd_pkg::OP_ADD: begin
              if (in_den == '0 || used >= CW'(N)) out_st <= gbcd_pkg::ST_REJECT;
              else begin
                wal_val[used[IW-1:0]] <= in_den;
                wal_cnt[used[IW-1:0]] <= in_cnt;
                used   <= used + 1'b1;
                out_st <= gbcd_pkg::ST_ACCEPT;
              end
            end
            default: out_st <= gbcd_pkg::ST_REJECT;
          endcase
        end
        gbcd_pkg::S_SORT_RD: begin
          if (i >= used) i <= '0;
          else begin
            v_val <= wal_val[i[IW-1:0]];
            v_cnt <= wal_cnt[i[IW-1:0]];
            j     <= i;
          end
        end
        gbcd_pkg::S_SORT_CMP: begin
          if (j != '0) begin
            o_val <= wal_val[order[j[IW-1:0] - 1'b1]];
            o_cnt <= wal_cnt[order[j[IW-1:0] - 1'b1]];
          end
        end
        gbcd_pkg::S_SORT_PUT: begin
          // Shift one slot down while the new entry ranks ahead, else place it.
          if (sort_shift) begin
            order[j[IW-1:0]] <= order[j[IW-1:0] - 1'b1];
            j <= j - 1'b1;
          end else begin
            order[j[IW-1:0]] <= i[IW-1:0];
            i <= i + 1'b1;
          end
        end
        gbcd_pkg::S_DIV_RD: begin
          if (i >= used) i <= '0;
          else begin
            d_val <= wal_val[order[i[IW-1:0]]];
            d_cnt <= wal_cnt[order[i[IW-1:0]]];
          end
        end
        gbcd_pkg::S_DIV_WAIT: if (drsp.done) begin
          taken[i[IW-1:0]] <= take;
          rem <= rem - prod[W-1:0];
          if (take != '0) begin
            any_taken <= 1'b1;
            last_idx  <= i;
          end
          i <= i + 1'b1;
        end
        gbcd_pkg::S_CHECK: begin
          if (amt == '0) out_st <= gbcd_pkg::ST_NOTHING;
          else out_st <= gbcd_pkg::ST_FAIL;
        end
        // Hold the previous line until its transfer before loading the next.
        gbcd_pkg::S_EMIT_RD: if (!m_tvalid) begin
          out_den <= wal_val[order[i[IW-1:0]]];
          out_q   <= taken[i[IW-1:0]];
        end
        gbcd_pkg::S_EMIT: if (!m_tvalid) begin
          if (out_q != '0) begin
            out_st   <= gbcd_pkg::ST_LINE;
            out_last <= (i == last_idx);
            m_tvalid <= 1'b1;
          end
          i <= i + 1'b1;
        end
        gbcd_pkg::S_ONE: if (!m_tvalid) begin
          out_den  <= '0;
          out_q    <= '0;
          out_last <= 1'b1;
          m_tvalid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CW'(N)) else $error("entry count overflow");
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == gbcd_pkg::S_DECODE) else $error("accept lost");
  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_st == gbcd_pkg::ST_LINE |-> out_q != '0) else $error("empty line");
`endif

endmodule

`default_nettype wire
